/* rtl/cdq_pkg.sv */
`timescale 1ns / 1ps
// shared constants, codes and control types of the circular deque
// no dependencies

package cdq_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int OCC_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = OCC_W + 1;
   localparam int CMD_W  = 3;
   localparam int STAT_W = 2;
   localparam int DATA_W = 32;

   localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INS_REAR  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_REAR  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DISPLAY   = 3'd4;

   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OFS_WALK,
      OFS_WALK_NEXT,
      OFS_FRONT,
      OFS_REAR,
      OFS_TAIL
   } ofs_sel_type;

   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef struct packed {
      logic              req_take;
      ofs_sel_type       ofs_sel;
      logic              ram_wr;
      logic              ram_rd;
      ptr_op_type        head_op;
      ptr_op_type        occ_op;
      logic              walk_inc;
      logic              out_load;
      logic [STAT_W-1:0] out_status;
      logic              out_from_ram;
      logic              out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic walk_last;
      logic out_free;
   } dp_stat_type;

endpackage

/* rtl/cdq_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces for command and result words
// depends on cdq_pkg

interface cdq_req_if;
   logic                             valid;
   logic                             ready;
   logic [cdq_pkg::CMD_W-1:0]        command;
   logic signed [cdq_pkg::DATA_W-1:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink (input valid, input command, input value, output ready);
endinterface

interface cdq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [cdq_pkg::STAT_W-1:0]        status;
   logic signed [cdq_pkg::DATA_W-1:0] element;
   logic                              last;

   modport source (output valid, output status, output element, output last, input ready);
   modport sink (input valid, input status, input element, input last, output ready);
endinterface

/* rtl/cdq_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/cdq_ctrl.sv */
`timescale 1ns / 1ps
// controller of the circular deque: command latch and sequencing fsm
// depends on cdq_pkg

module cdq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [cdq_pkg::CMD_W-1:0] req_command,
   input  cdq_pkg::dp_stat_type      stat,
   output cdq_pkg::dp_cmd_type       cmd
);

   cdq_pkg::state_type        state_ff, state_in;
   logic [cdq_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic                      accept;
   logic                      is_delete;

   assign req_ready = (state_ff == cdq_pkg::ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign is_delete = (cmd_ff == cdq_pkg::CMD_DEL_FRONT) || (cmd_ff == cdq_pkg::CMD_DEL_REAR);

   always_comb begin
      cmd_in = accept ? req_command : cmd_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cdq_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = cdq_pkg::ST_EXEC;
            end
         end
         cdq_pkg::ST_EXEC: begin
            case (cmd_ff) inside
               cdq_pkg::CMD_INS_FRONT, cdq_pkg::CMD_INS_REAR: begin
                  if (stat.out_free) begin
                     state_in = cdq_pkg::ST_IDLE;
                  end
               end
               cdq_pkg::CMD_DEL_FRONT, cdq_pkg::CMD_DEL_REAR, cdq_pkg::CMD_DISPLAY: begin
                  if (!stat.empty) begin
                     state_in = cdq_pkg::ST_EMIT;
                  end else if (stat.out_free) begin
                     state_in = cdq_pkg::ST_IDLE;
                  end
               end
               default: begin
                  state_in = cdq_pkg::ST_IDLE;
               end
            endcase
         end
         cdq_pkg::ST_EMIT: begin
            if (stat.out_free && (is_delete || stat.walk_last)) begin
               state_in = cdq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cdq_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath commands
   always_comb begin
      cmd.req_take     = accept;
      cmd.ofs_sel      = cdq_pkg::OFS_WALK;
      cmd.ram_wr       = 1'b0;
      cmd.ram_rd       = 1'b0;
      cmd.head_op      = cdq_pkg::PTR_HOLD;
      cmd.occ_op       = cdq_pkg::PTR_HOLD;
      cmd.walk_inc     = 1'b0;
      cmd.out_load     = 1'b0;
      cmd.out_status   = cdq_pkg::STAT_DONE;
      cmd.out_from_ram = 1'b0;
      cmd.out_last     = 1'b1;
      unique case (state_ff)
         cdq_pkg::ST_IDLE: begin
         end
         cdq_pkg::ST_EXEC: begin
            case (cmd_ff) inside
               cdq_pkg::CMD_INS_FRONT, cdq_pkg::CMD_INS_REAR: begin
                  if (stat.out_free) begin
                     cmd.out_load = 1'b1;
                     if (stat.full) begin
                        cmd.out_status = cdq_pkg::STAT_FULL;
                     end else begin
                        cmd.ram_wr = 1'b1;
                        cmd.occ_op = cdq_pkg::PTR_INC;
                        if (cmd_ff == cdq_pkg::CMD_INS_FRONT) begin
                           cmd.ofs_sel = cdq_pkg::OFS_FRONT;
                           cmd.head_op = cdq_pkg::PTR_DEC;
                        end else begin
                           cmd.ofs_sel = cdq_pkg::OFS_REAR;
                        end
                     end
                  end
               end
               cdq_pkg::CMD_DEL_FRONT, cdq_pkg::CMD_DEL_REAR, cdq_pkg::CMD_DISPLAY: begin
                  if (!stat.empty) begin
                     cmd.ram_rd = 1'b1;
                     if (cmd_ff == cdq_pkg::CMD_DEL_FRONT) begin
                        cmd.head_op = cdq_pkg::PTR_INC;
                        cmd.occ_op  = cdq_pkg::PTR_DEC;
                     end else if (cmd_ff == cdq_pkg::CMD_DEL_REAR) begin
                        cmd.ofs_sel = cdq_pkg::OFS_TAIL;
                        cmd.occ_op  = cdq_pkg::PTR_DEC;
                     end
                  end else if (stat.out_free) begin
                     cmd.out_load   = 1'b1;
                     cmd.out_status = cdq_pkg::STAT_EMPTY;
                  end
               end
               default: begin
               end
            endcase
         end
         cdq_pkg::ST_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load     = 1'b1;
               cmd.out_from_ram = 1'b1;
               cmd.out_last     = is_delete || stat.walk_last;
               if (!(is_delete || stat.walk_last)) begin
                  cmd.walk_inc = 1'b1;
                  cmd.ram_rd   = 1'b1;
                  cmd.ofs_sel  = cdq_pkg::OFS_WALK_NEXT;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdq_pkg::ST_IDLE;
         cmd_ff   <= cdq_pkg::CMD_DISPLAY;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
      end
   end

endmodule

/* rtl/cdq_dp.sv */
`timescale 1ns / 1ps
// datapath of the circular deque: ring pointers, ring ram and result register
// depends on cdq_pkg and cdq_ram

module cdq_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [cdq_pkg::DATA_W-1:0]  req_value,
   input  cdq_pkg::dp_cmd_type                cmd,
   output cdq_pkg::dp_stat_type               stat,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [cdq_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [cdq_pkg::DATA_W-1:0]  rsp_element,
   output logic                               rsp_last
);

   logic [cdq_pkg::IDX_W-1:0]  head_ff, head_in;
   logic [cdq_pkg::OCC_W-1:0]  occ_ff, occ_in;
   logic [cdq_pkg::IDX_W-1:0]  walk_ff, walk_in;
   logic [cdq_pkg::DATA_W-1:0] value_ff, value_in;
   logic                       valid_ff, valid_in;
   logic [cdq_pkg::STAT_W-1:0] status_ff, status_in;
   logic [cdq_pkg::DATA_W-1:0] element_ff, element_in;
   logic                       last_ff, last_in;

   logic [cdq_pkg::OCC_W-1:0]  ofs;
   logic [cdq_pkg::SUM_W-1:0]  pos_sum;
   logic [cdq_pkg::SUM_W-1:0]  pos_wrap;
   logic [cdq_pkg::IDX_W-1:0]  ram_addr;
   logic [cdq_pkg::DATA_W-1:0] ram_rdata;

   // ring position of head plus offset, modulo depth
   always_comb begin
      case (cmd.ofs_sel)
         cdq_pkg::OFS_WALK:      ofs = cdq_pkg::OCC_W'(walk_ff);
         cdq_pkg::OFS_WALK_NEXT: ofs = cdq_pkg::OCC_W'(walk_ff) + cdq_pkg::OCC_W'(1);
         cdq_pkg::OFS_FRONT:     ofs = cdq_pkg::OCC_W'(cdq_pkg::DEPTH - 1);
         cdq_pkg::OFS_REAR:      ofs = occ_ff;
         cdq_pkg::OFS_TAIL:      ofs = occ_ff - cdq_pkg::OCC_W'(1);
         default:                ofs = cdq_pkg::OCC_W'(walk_ff);
      endcase
      pos_sum  = cdq_pkg::SUM_W'(head_ff) + cdq_pkg::SUM_W'(ofs);
      pos_wrap = (pos_sum >= cdq_pkg::SUM_W'(cdq_pkg::DEPTH))
                 ? pos_sum - cdq_pkg::SUM_W'(cdq_pkg::DEPTH) : pos_sum;
      ram_addr = pos_wrap[cdq_pkg::IDX_W-1:0];
   end

   cdq_ram #(
      .WIDTH (cdq_pkg::DATA_W),
      .DEPTH (cdq_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.ram_wr),
      .wr_addr (ram_addr),
      .wr_data (value_ff),
      .rd_en   (cmd.ram_rd),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      case (cmd.head_op)
         cdq_pkg::PTR_INC: begin
            head_in = (head_ff == cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1))
                      ? '0 : head_ff + cdq_pkg::IDX_W'(1);
         end
         cdq_pkg::PTR_DEC: begin
            head_in = (head_ff == '0)
                      ? cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1) : head_ff - cdq_pkg::IDX_W'(1);
         end
         default: head_in = head_ff;
      endcase
      case (cmd.occ_op)
         cdq_pkg::PTR_INC: occ_in = occ_ff + cdq_pkg::OCC_W'(1);
         cdq_pkg::PTR_DEC: occ_in = occ_ff - cdq_pkg::OCC_W'(1);
         default:          occ_in = occ_ff;
      endcase
      if (cmd.req_take) begin
         walk_in = '0;
      end else if (cmd.walk_inc) begin
         walk_in = walk_ff + cdq_pkg::IDX_W'(1);
      end else begin
         walk_in = walk_ff;
      end
      value_in = cmd.req_take ? req_value : value_ff;
   end

   // result word register
   always_comb begin
      valid_in   = valid_ff && !rsp_ready;
      status_in  = status_ff;
      element_in = element_ff;
      last_in    = last_ff;
      if (cmd.out_load) begin
         valid_in   = 1'b1;
         status_in  = cmd.out_status;
         element_in = cmd.out_from_ram ? ram_rdata : '0;
         last_in    = cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         occ_ff   <= '0;
         walk_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         occ_ff   <= occ_in;
         walk_ff  <= walk_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      status_ff  <= status_in;
      element_ff <= element_in;
      last_ff    <= last_in;
   end

   assign stat.empty     = (occ_ff == '0);
   assign stat.full      = (occ_ff == cdq_pkg::OCC_W'(cdq_pkg::DEPTH));
   assign stat.walk_last = ((cdq_pkg::OCC_W'(walk_ff) + cdq_pkg::OCC_W'(1)) == occ_ff);
   assign stat.out_free  = !valid_ff || rsp_ready;

   assign rsp_valid   = valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_element = element_ff;
   assign rsp_last    = last_ff;

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= cdq_pkg::OCC_W'(cdq_pkg::DEPTH))
      else $error("occupancy beyond ring depth");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff < cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1) || head_ff == cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1))
      else $error("head index outside ring");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("result register overwritten while held");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      cmd.ram_wr |=> occ_ff == $past(occ_ff) + cdq_pkg::OCC_W'(1))
      else $error("insert without occupancy growth");

   a_read_held: assert property (@(posedge clock) disable iff (reset)
      cmd.ram_rd |-> !stat.empty)
      else $error("ring read while empty");

endmodule

/* rtl/circular_deque_unit.sv */
`timescale 1ns / 1ps
// top level of the circular deque: controller plus datapath
// depends on cdq_pkg, cdq_if, cdq_ctrl and cdq_dp
//
//  channel  dir  word fields                 handshake
//  req_ch   in   command[2:0] value[31:0]    valid/ready
//  rsp_ch   out  status[1:0] element[31:0]   valid/ready, last marks final word
//
// insert, or delete or display on an empty ring: take, then execute
// unknown command: take, then execute, and no word; delete: take, ring read, result
// display: take, ring read, then one element a cycle while rsp_ch is not stalled, paced by
// the registered ram read and the result register
// reset clears head and occupancy at once; ring contents need no clearing
// req_ch is ready only between commands and out of reset; a stalled rsp_ch holds the word

module circular_deque_unit (
   input  logic       clock,
   input  logic       reset,
   cdq_req_if.sink    req_ch,
   cdq_rsp_if.source  rsp_ch
);

   cdq_pkg::dp_cmd_type  dp_cmd;
   cdq_pkg::dp_stat_type dp_stat;

   cdq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_command (req_ch.command),
      .stat        (dp_stat),
      .cmd         (dp_cmd)
   );

   cdq_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_value   (req_ch.value),
      .cmd         (dp_cmd),
      .stat        (dp_stat),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_status  (rsp_ch.status),
      .rsp_element (rsp_ch.element),
      .rsp_last    (rsp_ch.last)
   );

endmodule
